>>> hw/rtl/lewt_pkg.sv
// Shared types, codes and sizes for the lease expiry watchdog table.
`default_nettype none

package lewt_pkg;

  // Default number of lease slots
  localparam int LEASE_SLOTS_DEF = 16;

  // Request function codes
  localparam logic [1:0] F_ADD     = 2'd0;
  localparam logic [1:0] F_TICK    = 2'd1;
  localparam logic [1:0] F_OUTCOME = 2'd2;

  // Result kinds
  localparam logic [1:0] K_ADD     = 2'd0;
  localparam logic [1:0] K_RESUME  = 2'd1;
  localparam logic [1:0] K_SUMMARY = 2'd2;
  localparam logic [1:0] K_OUTCOME = 2'd3;

  // Resume answer codes; anything else counts as failed
  localparam logic [1:0] OC_OK        = 2'd0;
  localparam logic [1:0] OC_NOT_FOUND = 2'd1;

  // Slot state codes
  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_PAUSED   = 3'd1;
  localparam logic [2:0] ST_RESUMING = 3'd2;
  localparam logic [2:0] ST_ROLLED   = 3'd3;
  localparam logic [2:0] ST_FAILED   = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUTC,
    S_SUM
  } fsm_t;

  // Input request
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] process_identity;
    logic [63:0] time_ns;
    logic [3:0]  slot_index;
    logic [1:0]  outcome_code;
  } req_t;

  // Result
  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [3:0]  slot;
    logic [63:0] identity_out;
    logic [4:0]  active_count;
    logic [31:0] rollback_count;
    logic [31:0] failure_count;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/lease_expiry_watchdog_table.sv
// Lease expiry watchdog table: slot memories and scan sequencer.
//
//  Channel | Ports                     | Handshake
//  --------+---------------------------+------------------------------------
//  request | start, busy, in_req       | taken when start=1 and busy=0
//  result  | out_valid, out_rsp        | one-cycle strobe, cannot be stalled
//
// Add: refused from idle for zero expiry, else scans until a slot is claimed
// or the last is reached. Tick: scans all slots, then the summary. Outcome:
// reads the named slot, or answers from idle when out of range. The scan reads
// one slot per cycle (registered reads), so the slot count sets its length.
// Reset clears the slot valid bits and counters; no clearing pass is needed.
// Results leave through a register in the cycle after they are formed; the
// receiver cannot stall them.
`default_nettype none

module lease_expiry_watchdog_table #(
  parameter int LEASE_SLOTS = lewt_pkg::LEASE_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire lewt_pkg::req_t in_req,
  output logic                out_valid,
  output lewt_pkg::rsp_t      out_rsp
);

  localparam int SLOT_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

  lewt_pkg::fsm_t fsm_r, fsm_nxt;
  lewt_pkg::req_t req_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  // Slot memories
  logic [2:0]   st_mem [LEASE_SLOTS];
  logic [127:0] dat_mem [LEASE_SLOTS];
  logic [LEASE_SLOTS-1:0] vld_r;

  logic [2:0]   rd_st_r;
  logic         rd_vld_r;
  logic [127:0] rd_dat_r;

  logic              st_we;
  logic [2:0]        st_wd;
  logic              dat_we;

  logic [4:0]  act_r, act_nxt;
  logic [31:0] roll_r, roll_nxt;
  logic [31:0] fail_r, fail_nxt;

  logic            out_valid_r, out_valid_nxt;
  lewt_pkg::rsp_t  out_rsp_r, out_rsp_nxt;

  logic       accept;
  logic       in_range;
  logic [2:0] cur_st;
  logic       is_last;
  logic       add_hit;
  logic       due;
  logic       oc_hit;

  assign busy      = (fsm_r != lewt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (32'(in_req.slot_index) < LEASE_SLOTS);
  assign cur_st    = rd_vld_r ? rd_st_r : lewt_pkg::ST_EMPTY;
  assign is_last   = (idx_r == SLOT_W'(LEASE_SLOTS - 1));
  assign add_hit   = (req_r.func == lewt_pkg::F_ADD) && (cur_st == lewt_pkg::ST_EMPTY);
  assign due       = (req_r.func == lewt_pkg::F_TICK) && (cur_st == lewt_pkg::ST_PAUSED) &&
                     (req_r.time_ns >= rd_dat_r[63:0]);
  assign oc_hit    = (cur_st == lewt_pkg::ST_RESUMING);

  // Pick the slot to read next: start of scan or reported slot, then step
  always_comb begin
    idx_nxt = idx_r;
    if (fsm_r == lewt_pkg::S_IDLE) begin
      idx_nxt = (in_req.func == lewt_pkg::F_OUTCOME) ? SLOT_W'(in_req.slot_index) : '0;
    end else if (fsm_r == lewt_pkg::S_SCAN && !is_last) begin
      idx_nxt = idx_r + SLOT_W'(1);
    end
  end

  // Next state
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      lewt_pkg::S_IDLE: begin
        if (accept) begin
          priority if (in_req.func == lewt_pkg::F_ADD) begin
            fsm_nxt = (in_req.time_ns != 64'd0) ? lewt_pkg::S_SCAN : lewt_pkg::S_IDLE;
          end else if (in_req.func == lewt_pkg::F_TICK) begin
            fsm_nxt = lewt_pkg::S_SCAN;
          end else if (in_req.func == lewt_pkg::F_OUTCOME) begin
            fsm_nxt = in_range ? lewt_pkg::S_OUTC : lewt_pkg::S_IDLE;
          end else begin
            fsm_nxt = lewt_pkg::S_IDLE;
          end
        end
      end
      lewt_pkg::S_SCAN: begin
        if (req_r.func == lewt_pkg::F_ADD) begin
          if (add_hit || is_last) fsm_nxt = lewt_pkg::S_IDLE;
        end else if (is_last) begin
          fsm_nxt = lewt_pkg::S_SUM;
        end
      end
      lewt_pkg::S_OUTC: fsm_nxt = lewt_pkg::S_IDLE;
      lewt_pkg::S_SUM:  fsm_nxt = lewt_pkg::S_IDLE;
      default:          fsm_nxt = lewt_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory writes, counter updates and the next result
  always_comb begin
    st_we         = 1'b0;
    st_wd         = lewt_pkg::ST_EMPTY;
    dat_we        = 1'b0;
    act_nxt       = act_r;
    roll_nxt      = roll_r;
    fail_nxt      = fail_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    unique case (fsm_r)
      lewt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_req.func == lewt_pkg::F_ADD && in_req.time_ns == 64'd0) begin
            out_valid_nxt        = 1'b1;
            out_rsp_nxt.kind     = lewt_pkg::K_ADD;
          end else if (in_req.func == lewt_pkg::F_OUTCOME && !in_range) begin
            out_valid_nxt        = 1'b1;
            out_rsp_nxt.kind     = lewt_pkg::K_OUTCOME;
            out_rsp_nxt.slot     = in_req.slot_index;
          end
        end
      end
      lewt_pkg::S_SCAN: begin
        if (req_r.func == lewt_pkg::F_ADD) begin
          // Claim the first empty slot, or refuse at the end of the table
          if (add_hit) begin
            st_we                    = 1'b1;
            st_wd                    = lewt_pkg::ST_PAUSED;
            dat_we                   = 1'b1;
            act_nxt                  = act_r + 5'd1;
            out_valid_nxt            = 1'b1;
            out_rsp_nxt.kind         = lewt_pkg::K_ADD;
            out_rsp_nxt.accepted     = 1'b1;
            out_rsp_nxt.slot         = 4'(idx_r);
            out_rsp_nxt.identity_out = req_r.process_identity;
          end else if (is_last) begin
            out_valid_nxt            = 1'b1;
            out_rsp_nxt.kind         = lewt_pkg::K_ADD;
          end
        end else if (due) begin
          // Mark an expired paused slot resuming and request its resume
          st_we                    = 1'b1;
          st_wd                    = lewt_pkg::ST_RESUMING;
          act_nxt                  = act_r - 5'd1;
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.kind         = lewt_pkg::K_RESUME;
          out_rsp_nxt.accepted     = 1'b1;
          out_rsp_nxt.slot         = 4'(idx_r);
          out_rsp_nxt.identity_out = rd_dat_r[127:64];
        end
      end
      lewt_pkg::S_OUTC: begin
        out_valid_nxt    = 1'b1;
        out_rsp_nxt.kind = lewt_pkg::K_OUTCOME;
        out_rsp_nxt.slot = req_r.slot_index;
        if (oc_hit) begin
          st_we = 1'b1;
          if (req_r.outcome_code == lewt_pkg::OC_OK ||
              req_r.outcome_code == lewt_pkg::OC_NOT_FOUND) begin
            st_wd    = lewt_pkg::ST_ROLLED;
            roll_nxt = roll_r + 32'd1;
          end else begin
            st_wd    = lewt_pkg::ST_FAILED;
            fail_nxt = fail_r + 32'd1;
          end
          out_rsp_nxt.accepted     = 1'b1;
          out_rsp_nxt.identity_out = rd_dat_r[127:64];
        end
      end
      lewt_pkg::S_SUM: begin
        out_valid_nxt        = 1'b1;
        out_rsp_nxt.kind     = lewt_pkg::K_SUMMARY;
        out_rsp_nxt.accepted = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    out_rsp_nxt.active_count   = act_nxt;
    out_rsp_nxt.rollback_count = roll_nxt;
    out_rsp_nxt.failure_count  = fail_nxt;
    out_rsp_nxt.last           = (out_rsp_nxt.kind != lewt_pkg::K_RESUME);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= lewt_pkg::S_IDLE;
      vld_r       <= '0;
      act_r       <= '0;
      roll_r      <= '0;
      fail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      act_r       <= act_nxt;
      roll_r      <= roll_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_we) vld_r[idx_r] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_req;
    idx_r     <= idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // State memory: write the scanned slot, read the next one
  always_ff @(posedge clk) begin
    if (st_we) st_mem[idx_r] <= st_wd;
    rd_st_r  <= st_mem[idx_nxt];
    rd_vld_r <= vld_r[idx_nxt];
  end

  // Identity and expiry memory
  always_ff @(posedge clk) begin
    if (dat_we) dat_mem[idx_r] <= {req_r.process_identity, req_r.time_ns};
    rd_dat_r <= dat_mem[idx_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A result only follows a taken request or a busy cycle
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start || busy))
    else $error("result without a request in progress");

  // Resume requests never close a request
  a_resume_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.kind == lewt_pkg::K_RESUME) |-> !out_rsp_r.last)
    else $error("resume request marked last");

  // The summary state always yields the closing summary
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == lewt_pkg::S_SUM) |=>
      (out_valid_r && out_rsp_r.kind == lewt_pkg::K_SUMMARY && out_rsp_r.last))
    else $error("tick summary missing");

  // Slot memory is written only while a request is being worked
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (fsm_r == lewt_pkg::S_SCAN || fsm_r == lewt_pkg::S_OUTC))
    else $error("slot write outside scan or outcome");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the lease expiry watchdog table.
`timescale 1ns / 1ps

import lewt_pkg::*;

// Tracks the lease table from accepted requests and checks every result against it.
class lease_scoreboard;
  localparam int SLOTS = LEASE_SLOTS_DEF;

  logic [2:0]  lease_state  [SLOTS];
  logic [63:0] lease_ident  [SLOTS];
  logic [63:0] lease_expiry [SLOTS];
  logic [4:0]  paused_count;
  logic [31:0] rollbacks;
  logic [31:0] failures;
  rsp_t        expected_rsp [$];
  int          mismatches;

  function new();
    foreach (lease_state[i]) begin
      lease_state[i]  = ST_EMPTY;
      lease_ident[i]  = '0;
      lease_expiry[i] = '0;
    end
    paused_count = '0;
    rollbacks    = '0;
    failures     = '0;
    mismatches   = 0;
  endfunction

  // Queue one result carrying the counters as they stand now.
  function void queue_result(logic [1:0] kind, logic acc, logic [3:0] slot,
                             logic [63:0] ident, logic last);
    rsp_t r;
    r.kind           = kind;
    r.accepted       = acc;
    r.slot           = slot;
    r.identity_out   = ident;
    r.active_count   = paused_count;
    r.rollback_count = rollbacks;
    r.failure_count  = failures;
    r.last           = last;
    expected_rsp.push_back(r);
  endfunction

  // Apply one accepted request and queue the results it causes.
  function void note_request(req_t q);
    bit placed;
    placed = 1'b0;
    case (q.func)
      F_ADD: begin
        if (q.time_ns != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && lease_state[i] == ST_EMPTY) begin
              lease_state[i]  = ST_PAUSED;
              lease_ident[i]  = q.process_identity;
              lease_expiry[i] = q.time_ns;
              paused_count    = paused_count + 5'd1;
              queue_result(K_ADD, 1'b1, 4'(i), q.process_identity, 1'b1);
              placed = 1'b1;
            end
          end
        end
        if (!placed) queue_result(K_ADD, 1'b0, 4'd0, 64'd0, 1'b1);
      end
      F_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (lease_state[i] == ST_PAUSED && q.time_ns >= lease_expiry[i]) begin
            lease_state[i] = ST_RESUMING;
            paused_count   = paused_count - 5'd1;
            queue_result(K_RESUME, 1'b1, 4'(i), lease_ident[i], 1'b0);
          end
        end
        queue_result(K_SUMMARY, 1'b1, 4'd0, 64'd0, 1'b1);
      end
      F_OUTCOME: begin
        if (int'(q.slot_index) < SLOTS && lease_state[q.slot_index] == ST_RESUMING) begin
          if (q.outcome_code == OC_OK || q.outcome_code == OC_NOT_FOUND) begin
            lease_state[q.slot_index] = ST_ROLLED;
            rollbacks = rollbacks + 32'd1;
          end else begin
            lease_state[q.slot_index] = ST_FAILED;
            failures = failures + 32'd1;
          end
          queue_result(K_OUTCOME, 1'b1, q.slot_index, lease_ident[q.slot_index], 1'b1);
        end else begin
          queue_result(K_OUTCOME, 1'b0, q.slot_index, 64'd0, 1'b1);
        end
      end
      default: ;  // unused function code: no result
    endcase
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(rsp_t got);
    rsp_t want;
    if (expected_rsp.size() == 0) begin
      $error("unexpected result: kind %0d slot %0d", got.kind, got.slot);
      mismatches++;
      return;
    end
    want = expected_rsp.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("accepted", want.accepted, got.accepted);
    check_field("slot", want.slot, got.slot);
    check_field("identity_out", want.identity_out, got.identity_out);
    check_field("active_count", want.active_count, got.active_count);
    check_field("rollback_count", want.rollback_count, got.rollback_count);
    check_field("failure_count", want.failure_count, got.failure_count);
    check_field("last", want.last, got.last);
  endfunction

  function int outstanding();
    return expected_rsp.size();
  endfunction

  function int free_slots();
    int cnt;
    cnt = 0;
    foreach (lease_state[i]) if (lease_state[i] == ST_EMPTY) cnt++;
    return cnt;
  endfunction

  // Return a random slot that awaits its outcome, or -1 when there is none.
  function int pick_resuming();
    int cands [$];
    foreach (lease_state[i]) if (lease_state[i] == ST_RESUMING) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction
endclass

module testbench;
  localparam logic [1:0] F_UNUSED    = 2'd3;
  localparam logic [1:0] OC_FAIL     = 2'd2;
  localparam logic [1:0] OC_FAIL_ALT = 2'd3;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_EVERY  = 110;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [63:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_valid;
  rsp_t out_rsp;

  lease_scoreboard sb;
  bit idle_enabled = 1'b1;
  int cycle_count = 0;

  lease_expiry_watchdog_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample the request and result channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_result(out_rsp);
    end
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t make_req(logic [1:0] f, logic [63:0] ident, logic [63:0] t,
                                    logic [3:0] idx, logic [1:0] code);
    req_t q;
    q.func             = f;
    q.process_identity = ident;
    q.time_ns          = t;
    q.slot_index       = idx;
    q.outcome_code     = code;
    return q;
  endfunction

  // Optionally idle, then hold the request until the block takes it.
  // Called and returns at a falling edge.
  task automatic issue(req_t q);
    bit taken;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= q;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // Drop start and hold off until every expected result has come.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] now;
    logic [63:0] t;
    int n;
    int pick;
    int rs;

    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, due-time equality, refused adds and outcomes.
    issue(make_req(F_ADD, ALL_ONES, ALL_ONES, 4'hf, 2'd3));
    issue(make_req(F_ADD, 64'd0, 64'd0, 4'd0, 2'd0));
    issue(make_req(F_ADD, rand64(), 64'd1, 4'd0, 2'd0));
    issue(make_req(F_ADD, rand64(), 64'd100, 4'd0, 2'd0));
    issue(make_req(F_ADD, rand64(), 64'd101, 4'd0, 2'd0));
    issue(make_req(F_TICK, ALL_ONES, 64'd0, 4'hf, 2'd3));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd1, OC_OK));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd5, OC_OK));
    issue(make_req(F_UNUSED, ALL_ONES, ALL_ONES, 4'hf, 2'd3));
    issue(make_req(F_TICK, 64'd0, 64'd1, 4'd0, 2'd0));
    issue(make_req(F_TICK, 64'd0, 64'd100, 4'd0, 2'd0));
    issue(make_req(F_TICK, 64'd0, 64'd101, 4'd0, 2'd0));
    issue(make_req(F_OUTCOME, ALL_ONES, ALL_ONES, 4'd1, OC_OK));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd2, OC_NOT_FOUND));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd3, OC_FAIL));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd1, OC_OK));
    issue(make_req(F_TICK, 64'd0, ALL_ONES, 4'd0, 2'd0));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'd0, OC_FAIL_ALT));
    issue(make_req(F_OUTCOME, 64'd0, 64'd0, 4'hf, OC_FAIL_ALT));
    issue(make_req(F_TICK, 64'd0, ALL_ONES, 4'd0, 2'd0));

    // Random: lease lifecycles with random content, mixed with noise.
    now = 64'd5000;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) idle_enabled = 1'b0;
      pick = $urandom_range(0, 99);
      rs = sb.pick_resuming();
      if (pick < 3) begin
        issue(make_req(F_UNUSED, rand64(), rand64(), 4'($urandom), 2'($urandom)));
        continue;
      end
      if (pick < 6) begin
        t = ($urandom_range(0, 2) == 0) ? rand64() : now + 64'($urandom_range(1, 3000));
        issue(make_req(F_ADD, rand64(), t, 4'($urandom), 2'($urandom)));
      end else if (pick < 8) begin
        issue(make_req(F_ADD, rand64(), 64'd0, 4'($urandom), 2'($urandom)));
      end else if (pick < 36 && rs >= 0) begin
        issue(make_req(F_OUTCOME, rand64(), rand64(), 4'(rs), 2'($urandom)));
      end else if (pick < 44) begin
        issue(make_req(F_OUTCOME, rand64(), rand64(), 4'($urandom), 2'($urandom)));
      end else begin
        if ($urandom_range(0, 29) == 0) begin
          t = rand64();
        end else begin
          now = now + 64'($urandom_range(0, 300));
          t = now;
        end
        issue(make_req(F_TICK, rand64(), t, 4'($urandom), 2'($urandom)));
      end
      n++;
      if (n % DRAIN_EVERY == 0) drain_results();
    end

    // Fill the table, knock on it while full, then resume and settle everything.
    while (sb.free_slots() > 0)
      issue(make_req(F_ADD, rand64(), now + 64'($urandom_range(1, 50)), 4'($urandom),
                     2'($urandom)));
    repeat (2) issue(make_req(F_ADD, rand64(), rand64() | 64'd1, 4'($urandom), 2'($urandom)));
    issue(make_req(F_TICK, rand64(), ALL_ONES, 4'($urandom), 2'($urandom)));
    rs = sb.pick_resuming();
    while (rs >= 0) begin
      issue(make_req(F_OUTCOME, rand64(), rand64(), 4'(rs), 2'($urandom)));
      rs = sb.pick_resuming();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/lewt_pkg.sv
hw/rtl/lease_expiry_watchdog_table.sv
dv/testbench.sv
